[rtl/pure_pursuit_steering_top_macros.svh]
// Assertion macros shared by the pure pursuit steering RTL.
`ifndef PURE_PURSUIT_STEERING_TOP_MACROS_SVH
`define PURE_PURSUIT_STEERING_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked property with an explicit clock and active-low reset.
`define PPST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same, on the standard clk_i / rst_ni pair.
`define PPST_CHECK(lbl, prop, msg) `PPST_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`else
`define PPST_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPST_CHECK(lbl, prop, msg)
`endif

`endif

[rtl/ppst_pkg.sv]
// Types, widths and the arctangent table for the pure pursuit steering block.
`default_nettype none
package ppst_pkg;

  localparam int unsigned QUOT_W     = 26;  // quotient never exceeds 2^25
  localparam int unsigned DEN_W      = 32;
  localparam int unsigned MAG_W      = 41;
  localparam int unsigned CURV_W     = 32;
  localparam int unsigned WB_W       = 16;
  localparam int unsigned FB_W       = 31;
  localparam int unsigned PROD_W     = 49;
  localparam int unsigned XY_W       = 52;
  localparam int unsigned Z_W        = 34;
  localparam int unsigned ANGLE_W    = 15;
  localparam int unsigned TABLE_SIZE = 24;
  localparam int          ANGLE_LIMIT = 12868;

  typedef enum logic {
    REG_WHEEL_BASE = 1'b0,
    REG_FALLBACK   = 1'b1
  } cfg_reg_e;

  // Sideband carried through the divider.
  typedef struct packed {
    logic neg;
    logic zero;
  } div_tag_t;

  // Sideband carried through the CORDIC.
  typedef struct packed {
    logic [CURV_W-1:0] curv;
    logic              clip;
  } cord_tag_t;

  // atan(2^-idx) in Q.30, truncated.
  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/ppst_div.sv]
// Pipelined restoring divider: one quotient bit per register stage.
`default_nettype none
module ppst_div import ppst_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire logic [DEN_W-1:0]   den_i,
  input  wire logic [MAG_W-1:0]   mag_i,
  input  wire div_tag_t           tag_i,
  output logic                    vld_o,
  output logic [QUOT_W-1:0]       quot_o,
  output div_tag_t                tag_o
);

  logic                  v_q [QUOT_W];
  logic [DEN_W-1:0]      d_q [QUOT_W];
  logic [DEN_W-1:0]      p_q [QUOT_W];
  logic [QUOT_W-1:0]     m_q [QUOT_W];
  logic [QUOT_W-1:0]     q_q [QUOT_W];
  div_tag_t              t_q [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  d_in;
    logic [DEN_W-1:0]  p_in;
    logic [QUOT_W-1:0] m_in;
    logic [QUOT_W-1:0] q_in;
    div_tag_t          t_in;
    logic [DEN_W:0]    trial;
    logic              ge;

    if (k == 0) begin : g_first
      // Top dividend bits are below the divisor since the quotient fits QUOT_W.
      assign v_in = vld_i;
      assign d_in = den_i;
      assign p_in = {{(DEN_W-(MAG_W-QUOT_W)){1'b0}}, mag_i[MAG_W-1:QUOT_W]};
      assign m_in = mag_i[QUOT_W-1:0];
      assign q_in = '0;
      assign t_in = tag_i;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign d_in = d_q[k-1];
      assign p_in = p_q[k-1];
      assign m_in = m_q[k-1];
      assign q_in = q_q[k-1];
      assign t_in = t_q[k-1];
    end

    // Bring down the next dividend bit, subtract when it fits.
    assign trial = {p_in, m_in[QUOT_W-1]};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k] <= d_in;
        p_q[k] <= ge ? DEN_W'(trial - {1'b0, d_in}) : trial[DEN_W-1:0];
        m_q[k] <= {m_in[QUOT_W-2:0], 1'b0};
        q_q[k] <= {q_in[QUOT_W-2:0], ge};
        t_q[k] <= t_in;
      end
    end
  end

  assign vld_o  = v_q[QUOT_W-1];
  assign quot_o = q_q[QUOT_W-1];
  assign tag_o  = t_q[QUOT_W-1];

endmodule
`default_nettype wire

[rtl/ppst_cordic.sv]
// Pipelined vectoring CORDIC arctangent with Q2.13 rounding and clamp.
`default_nettype none
module ppst_cordic import ppst_pkg::*; #(
  parameter int STAGES = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      vld_i,
  input  wire logic signed [PROD_W-1:0]  y_i,
  input  wire cord_tag_t                 tag_i,
  output logic                           vld_o,
  output logic signed [ANGLE_W-1:0]      angle_o,
  output cord_tag_t                      tag_o
);

  localparam int NS = (STAGES > int'(TABLE_SIZE)) ? int'(TABLE_SIZE) : STAGES;
  localparam logic signed [XY_W-1:0] X_INIT = XY_W'(64'sd268435456);

  logic                   v_q [NS];
  logic signed [XY_W-1:0] x_q [NS];
  logic signed [XY_W-1:0] y_q [NS];
  logic signed [Z_W-1:0]  z_q [NS];
  cord_tag_t              t_q [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic                   v_in;
    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [Z_W-1:0]  z_in;
    cord_tag_t              t_in;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    if (i == 0) begin : g_first
      assign v_in = vld_i;
      assign x_in = X_INIT;
      assign y_in = XY_W'(y_i);
      assign z_in = '0;
      assign t_in = tag_i;
    end else begin : g_next
      assign v_in = v_q[i-1];
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign t_in = t_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    // Rotate toward the x axis, accumulate the angle.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_in[XY_W-1]) begin
          x_q[i] <= x_in + dx;
          y_q[i] <= y_in - dy;
          z_q[i] <= z_in + atan_q30(i);
        end else begin
          x_q[i] <= x_in - dx;
          y_q[i] <= y_in + dy;
          z_q[i] <= z_in - atan_q30(i);
        end
        t_q[i] <= t_in;
      end
    end
  end

  // Round to Q2.13 and clamp.
  logic signed [Z_W-1:0] z_rnd;
  logic signed [Z_W-1:0] z_sh;
  logic signed [ANGLE_W-1:0] ang_d;

  assign z_rnd = z_q[NS-1] + Z_W'(64'sd65536);
  assign z_sh  = z_rnd >>> 17;

  always_comb begin
    if (z_sh > Z_W'(ANGLE_LIMIT)) begin
      ang_d = ANGLE_W'(ANGLE_LIMIT);
    end else if (z_sh < -Z_W'(ANGLE_LIMIT)) begin
      ang_d = -ANGLE_W'(ANGLE_LIMIT);
    end else begin
      ang_d = z_sh[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_o <= ang_d;
      tag_o   <= t_q[NS-1];
    end
  end

endmodule
`default_nettype wire

[rtl/pure_pursuit_steering_top.sv]
// Throughput: one request per cycle while the output is not stalled; set by the
// one-bit-per-stage divider and one-iteration-per-stage CORDIC, both fully pipelined.
// The whole pipeline holds while the output result waits for tready.
// Reset clears all valid bits and loads wheel base = 11059, fallback = 65536.
`default_nettype none
`include "pure_pursuit_steering_top_macros.svh"
module pure_pursuit_steering_top import ppst_pkg::*; #(
  parameter int ATAN_STAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [30:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // point_x[15:0], point_y[31:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // path_curvature[31:0], steer_angle[46:32], 0
  output logic             m_axis_tuser    // clipped
);

  // Configuration registers.
  logic [WB_W-1:0] wb_q;
  logic [FB_W-1:0] fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= 16'd11059;
      fb_q <= 31'd65536;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WHEEL_BASE: wb_q <= cfg_data_i[WB_W-1:0];
        REG_FALLBACK:   fb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: hold everything while the output waits.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage A: squares and magnitude.
  logic signed [15:0] px, py;
  logic signed [31:0] sqx_full, sqy_full;
  logic        a_vld_q;
  logic [30:0] a_sqx_q, a_sqy_q;
  logic [15:0] a_abs_q;
  div_tag_t    a_tag_q;

  assign px       = s_axis_tdata[15:0];
  assign py       = s_axis_tdata[31:16];
  assign sqx_full = px * px;
  assign sqy_full = py * py;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_sqx_q      <= sqx_full[30:0];
      a_sqy_q      <= sqy_full[30:0];
      a_abs_q      <= px[15] ? 16'(-px) : px;
      a_tag_q.neg  <= px[15];
      a_tag_q.zero <= (px == 16'sd0) && (py == 16'sd0);
    end
  end

  // Stage B: denominator and shifted numerator.
  logic             b_vld_q;
  logic [DEN_W-1:0] b_den_q;
  logic [MAG_W-1:0] b_mag_q;
  div_tag_t         b_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_den_q <= {1'b0, a_sqx_q} + {1'b0, a_sqy_q};
      b_mag_q <= {a_abs_q, 25'd0};
      b_tag_q <= a_tag_q;
    end
  end

  // Divider.
  logic              dv_vld;
  logic [QUOT_W-1:0] dv_quot;
  div_tag_t          dv_tag;

  ppst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (b_vld_q),
    .den_i  (b_den_q),
    .mag_i  (b_mag_q),
    .tag_i  (b_tag_q),
    .vld_o  (dv_vld),
    .quot_o (dv_quot),
    .tag_o  (dv_tag)
  );

  // Stage C: sign, saturation and origin fallback.
  logic [CURV_W-1:0] q32;
  logic [CURV_W-1:0] curv_d;
  logic              clip_d;
  logic              c_vld_q;
  logic [CURV_W-1:0] c_curv_q;
  logic              c_clip_q;

  assign q32 = {{(CURV_W-QUOT_W){1'b0}}, dv_quot};

  always_comb begin
    clip_d = 1'b0;
    if (dv_tag.zero) begin
      curv_d = -{1'b0, fb_q};
    end else if (dv_tag.neg) begin
      if (q32 > 32'h8000_0000) begin
        curv_d = 32'h8000_0000;
        clip_d = 1'b1;
      end else begin
        curv_d = -q32;
      end
    end else begin
      if (q32 > 32'h7FFF_FFFF) begin
        curv_d = 32'h7FFF_FFFF;
        clip_d = 1'b1;
      end else begin
        curv_d = q32;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_curv_q <= curv_d;
      c_clip_q <= clip_d;
    end
  end

  // Stage D: wheel base times curvature.
  logic signed [PROD_W-1:0] prod_d;
  logic                     d_vld_q;
  logic signed [PROD_W-1:0] d_prod_q;
  cord_tag_t                d_tag_q;

  assign prod_d = $signed(c_curv_q) * $signed({1'b0, wb_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_prod_q     <= prod_d;
      d_tag_q.curv <= c_curv_q;
      d_tag_q.clip <= c_clip_q;
    end
  end

  // Arctangent; its last stage is the output register.
  logic signed [ANGLE_W-1:0] angle;
  cord_tag_t                 out_tag;

  ppst_cordic #(
    .STAGES (ATAN_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (d_vld_q),
    .y_i     (d_prod_q),
    .tag_i   (d_tag_q),
    .vld_o   (m_axis_tvalid),
    .angle_o (angle),
    .tag_o   (out_tag)
  );

  assign m_axis_tdata = {1'b0, angle, out_tag.curv};
  assign m_axis_tuser = out_tag.clip;

  // Checks.
  `PPST_CHECK(a_angle_range,
    m_axis_tvalid |-> (angle <= 15'sd12868) && (angle >= -15'sd12868),
    "steer angle beyond limit")
  `PPST_CHECK(a_clip_rail,
    m_axis_tvalid && m_axis_tuser |->
      (out_tag.curv == 32'h7FFF_FFFF) || (out_tag.curv == 32'h8000_0000),
    "clipped curvature not at a rail")
  `PPST_CHECK(a_stall_blocks_input,
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready,
    "input taken while output stalled")

endmodule
`default_nettype wire
